FILE: src/cau_pkg.sv
package cau_pkg;

  // Default datapath format: signed Q8.8
  localparam int unsigned WIDTH_DEF     = 16;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

endpackage

FILE: src/cau_if.sv
// Operand channel
interface cau_in_if #(
  parameter int unsigned WIDTH = cau_pkg::WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic signed [WIDTH-1:0] a_real;
  logic signed [WIDTH-1:0] a_imag;
  logic signed [WIDTH-1:0] b_real;
  logic signed [WIDTH-1:0] b_imag;

  modport source (output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// Result channel
interface cau_out_if #(
  parameter int unsigned WIDTH = cau_pkg::WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] res_real;
  logic signed [WIDTH-1:0] res_imag;
  logic                    overflow;
  logic                    div_zero;

  modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
  modport sink   (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

FILE: src/complex_arithmetic_unit.sv
// Complex ALU: add, subtract, multiply and divide of two complex operands in
// signed fixed point with FRAC_BITS fraction bits (Q8.8 by default). Takes one
// item per cycle while the output is not stalled; an accepted item passes through
// WIDTH+3 register stages (products, combine, one restoring-divider stage per
// quotient bit, output register), and all modes pass through the same stages
// so results stay in order.
// Multiply and divide truncate toward zero; out-of-range parts saturate and
// set overflow. Divide by zero returns zero with div_zero set.
module complex_arithmetic_unit #(
  parameter int unsigned WIDTH     = cau_pkg::WIDTH_DEF,
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  import cau_pkg::*;

  localparam int unsigned PW = 2*WIDTH;
  localparam int unsigned CW = 3*WIDTH + FRAC_BITS;
  localparam logic signed [PW:0] MAXV = {{(WIDTH+2){1'b0}}, {(WIDTH-1){1'b1}}};
  localparam logic signed [PW:0] MINV = ~MAXV;
  localparam logic signed [PW:0] RND  = (PW+1)'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [PW:0] ZERO = '0;
  localparam logic [WIDTH-1:0]   HALF = {1'b1, {(WIDTH-1){1'b0}}};

  typedef struct packed {
    logic                    is_div;
    logic                    dz;
    logic                    neg_re;
    logic                    neg_im;
    logic                    big_re;
    logic                    big_im;
    logic                    ovf;
    logic signed [WIDTH-1:0] res_re;
    logic signed [WIDTH-1:0] res_im;
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

  function automatic logic signed [WIDTH-1:0] sat_w(input logic signed [PW:0] v);
    if (v > MAXV) begin
      return MAXV[WIDTH-1:0];
    end else if (v < MINV) begin
      return MINV[WIDTH-1:0];
    end
    return v[WIDTH-1:0];
  endfunction

  function automatic logic out_rng(input logic signed [PW:0] v);
    return (v > MAXV) || (v < MINV);
  endfunction

  // {overflow, part} from quotient magnitude and sign
  function automatic logic [WIDTH:0] fin_part(input logic [WIDTH-1:0] q,
                                              input logic big, input logic neg);
    if (neg) begin
      if (big || (q > HALF)) begin
        return {1'b1, HALF};
      end
      return {1'b0, -q};
    end
    if (big || q[WIDTH-1]) begin
      return {1'b1, ~HALF};
    end
    return {1'b0, q};
  endfunction

  // ---------------- stage A: products ----------------
  logic                  a_valid, a_ready;
  logic [1:0]            a_mode;
  logic signed [PW-1:0]  p_rr, p_ii, p_ri, p_ir, bsq_r, bsq_i;
  logic signed [WIDTH:0] sum_re, sum_im;

  cau_prod #(.WIDTH(WIDTH)) u_prod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .valid_o  (a_valid),
    .ready_i  (a_ready),
    .mode_o   (a_mode),
    .p_rr_o   (p_rr),
    .p_ii_o   (p_ii),
    .p_ri_o   (p_ri),
    .p_ir_o   (p_ir),
    .bsq_r_o  (bsq_r),
    .bsq_i_o  (bsq_i),
    .sum_re_o (sum_re),
    .sum_im_o (sum_im)
  );

  // ---------------- stage B: combine ----------------
  logic signed [PW:0] m_re, m_im, n_re, n_im, t_re, t_im, s_re, s_im, ab_re, ab_im;
  logic [PW-1:0]      den_b;
  logic [CW-1:0]      dvd_re, dvd_im, den_w;
  side_t              side_b;

  assign m_re  = (PW+1)'(p_rr) - (PW+1)'(p_ii);
  assign m_im  = (PW+1)'(p_ri) + (PW+1)'(p_ir);
  assign n_re  = (PW+1)'(p_rr) + (PW+1)'(p_ii);
  assign n_im  = (PW+1)'(p_ir) - (PW+1)'(p_ri);
  assign den_b = $unsigned(bsq_r) + $unsigned(bsq_i);

  // multiply: truncate toward zero
  assign t_re = (m_re + (m_re[PW] ? RND : ZERO)) >>> FRAC_BITS;
  assign t_im = (m_im + (m_im[PW] ? RND : ZERO)) >>> FRAC_BITS;
  assign s_re = (a_mode == MODE_MUL) ? t_re : (PW+1)'(sum_re);
  assign s_im = (a_mode == MODE_MUL) ? t_im : (PW+1)'(sum_im);

  // divide: magnitudes, scaled dividend, quotient-too-large check
  assign ab_re  = n_re[PW] ? -n_re : n_re;
  assign ab_im  = n_im[PW] ? -n_im : n_im;
  assign dvd_re = CW'(ab_re[PW-1:0]) << FRAC_BITS;
  assign dvd_im = CW'(ab_im[PW-1:0]) << FRAC_BITS;
  assign den_w  = CW'(den_b) << WIDTH;

  always_comb begin
    side_b        = '0;
    side_b.is_div = (a_mode == MODE_DIV);
    side_b.dz     = (den_b == '0);
    side_b.neg_re = n_re[PW];
    side_b.neg_im = n_im[PW];
    side_b.big_re = dvd_re >= den_w;
    side_b.big_im = dvd_im >= den_w;
    side_b.ovf    = out_rng(s_re) || out_rng(s_im);
    side_b.res_re = sat_w(s_re);
    side_b.res_im = sat_w(s_im);
  end

  logic          b_valid_q, b_ready;
  side_t         b_side_q;
  logic [PW-1:0] b_den_q;
  logic [CW-1:0] b_rem_re_q, b_rem_im_q;

  assign a_ready = !b_valid_q || b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_ready) begin
      b_valid_q <= a_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid && a_ready) begin
      b_side_q   <= side_b;
      b_den_q    <= den_b;
      b_rem_re_q <= dvd_re;
      b_rem_im_q <= dvd_im;
    end
  end

  // ---------------- divider chain, MSB first ----------------
  logic              c_valid [WIDTH+1];
  logic              c_ready [WIDTH+1];
  logic [PW-1:0]     c_den   [WIDTH+1];
  logic [CW-1:0]     c_rre   [WIDTH+1];
  logic [CW-1:0]     c_rim   [WIDTH+1];
  logic [WIDTH-1:0]  c_qre   [WIDTH+1];
  logic [WIDTH-1:0]  c_qim   [WIDTH+1];
  logic [SIDE_W-1:0] c_side  [WIDTH+1];

  assign c_valid[0] = b_valid_q;
  assign b_ready    = c_ready[0];
  assign c_den[0]   = b_den_q;
  assign c_rre[0]   = b_rem_re_q;
  assign c_rim[0]   = b_rem_im_q;
  assign c_qre[0]   = '0;
  assign c_qim[0]   = '0;
  assign c_side[0]  = b_side_q;

  for (genvar i = 0; i < WIDTH; i++) begin : g_div
    cau_div_step #(
      .WIDTH     (WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .BIT       (WIDTH-1-i),
      .SIDE_W    (SIDE_W)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[i]),
      .in_ready_o  (c_ready[i]),
      .den_i       (c_den[i]),
      .rem_re_i    (c_rre[i]),
      .rem_im_i    (c_rim[i]),
      .q_re_i      (c_qre[i]),
      .q_im_i      (c_qim[i]),
      .side_i      (c_side[i]),
      .out_valid_o (c_valid[i+1]),
      .out_ready_i (c_ready[i+1]),
      .den_o       (c_den[i+1]),
      .rem_re_o    (c_rre[i+1]),
      .rem_im_o    (c_rim[i+1]),
      .q_re_o      (c_qre[i+1]),
      .q_im_o      (c_qim[i+1]),
      .side_o      (c_side[i+1])
    );
  end

  // ---------------- output stage ----------------
  side_t                   f_side;
  logic [WIDTH:0]          f_re, f_im;
  logic signed [WIDTH-1:0] o_re, o_im;
  logic                    o_ovf, o_dz;

  assign f_side = side_t'(c_side[WIDTH]);
  assign f_re   = fin_part(c_qre[WIDTH], f_side.big_re, f_side.neg_re);
  assign f_im   = fin_part(c_qim[WIDTH], f_side.big_im, f_side.neg_im);

  always_comb begin
    o_re  = f_side.res_re;
    o_im  = f_side.res_im;
    o_ovf = f_side.ovf;
    o_dz  = 1'b0;
    if (f_side.is_div) begin
      if (f_side.dz) begin
        o_re  = '0;
        o_im  = '0;
        o_ovf = 1'b0;
        o_dz  = 1'b1;
      end else begin
        o_re  = f_re[WIDTH-1:0];
        o_im  = f_im[WIDTH-1:0];
        o_ovf = f_re[WIDTH] || f_im[WIDTH];
      end
    end
  end

  logic                    out_valid_q;
  logic signed [WIDTH-1:0] out_re_q, out_im_q;
  logic                    out_ovf_q, out_dz_q;

  assign c_ready[WIDTH] = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (c_ready[WIDTH]) begin
      out_valid_q <= c_valid[WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid[WIDTH] && c_ready[WIDTH]) begin
      out_re_q  <= o_re;
      out_im_q  <= o_im;
      out_ovf_q <= o_ovf;
      out_dz_q  <= o_dz;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.res_real = out_re_q;
  assign out_o.res_imag = out_im_q;
  assign out_o.overflow = out_ovf_q;
  assign out_o.div_zero = out_dz_q;

`ifndef SYNTHESIS
  // a zero divisor yields a clean zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_dz_q) |-> (out_re_q == '0 && out_im_q == '0 && !out_ovf_q))
    else $error("div_zero result not zero");

  // a stalled item in stage B stays put
  a_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_ready) |=> (b_valid_q && $stable(b_side_q) && $stable(b_den_q)))
    else $error("stage B item lost under stall");

  // a result waiting at the output holds the tail of the divider back
  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !c_ready[WIDTH])
    else $error("divider advanced into a full output register");
`endif

endmodule

FILE: src/cau_prod.sv
module cau_prod #(
  parameter int unsigned WIDTH = cau_pkg::WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  cau_in_if.sink                    in_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [1:0]                mode_o,
  output logic signed [2*WIDTH-1:0] p_rr_o,
  output logic signed [2*WIDTH-1:0] p_ii_o,
  output logic signed [2*WIDTH-1:0] p_ri_o,
  output logic signed [2*WIDTH-1:0] p_ir_o,
  output logic signed [2*WIDTH-1:0] bsq_r_o,
  output logic signed [2*WIDTH-1:0] bsq_i_o,
  output logic signed [WIDTH:0]     sum_re_o,
  output logic signed [WIDTH:0]     sum_im_o
);
  import cau_pkg::*;

  logic                      valid_q;
  logic [1:0]                mode_q;
  logic signed [2*WIDTH-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, bsq_r_q, bsq_i_q;
  logic signed [WIDTH:0]     sum_re_q, sum_im_q;
  logic signed [WIDTH:0]     ar_x, ai_x, br_x, bi_x;
  logic                      take;

  assign in_i.ready = !valid_q || ready_i;
  assign take       = in_i.valid && in_i.ready;

  assign ar_x = (WIDTH+1)'(in_i.a_real);
  assign ai_x = (WIDTH+1)'(in_i.a_imag);
  assign br_x = (WIDTH+1)'(in_i.b_real);
  assign bi_x = (WIDTH+1)'(in_i.b_imag);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // partial products and add/sub
  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q   <= in_i.mode;
      p_rr_q   <= in_i.a_real * in_i.b_real;
      p_ii_q   <= in_i.a_imag * in_i.b_imag;
      p_ri_q   <= in_i.a_real * in_i.b_imag;
      p_ir_q   <= in_i.a_imag * in_i.b_real;
      bsq_r_q  <= in_i.b_real * in_i.b_real;
      bsq_i_q  <= in_i.b_imag * in_i.b_imag;
      sum_re_q <= (in_i.mode == MODE_SUB) ? ar_x - br_x : ar_x + br_x;
      sum_im_q <= (in_i.mode == MODE_SUB) ? ai_x - bi_x : ai_x + bi_x;
    end
  end

  assign valid_o  = valid_q;
  assign mode_o   = mode_q;
  assign p_rr_o   = p_rr_q;
  assign p_ii_o   = p_ii_q;
  assign p_ri_o   = p_ri_q;
  assign p_ir_o   = p_ir_q;
  assign bsq_r_o  = bsq_r_q;
  assign bsq_i_o  = bsq_i_q;
  assign sum_re_o = sum_re_q;
  assign sum_im_o = sum_im_q;

endmodule

FILE: src/cau_div_step.sv
module cau_div_step #(
  parameter int unsigned WIDTH     = cau_pkg::WIDTH_DEF,
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int unsigned BIT       = 0,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2*WIDTH-1:0]            den_i,
  input  logic [3*WIDTH+FRAC_BITS-1:0]  rem_re_i,
  input  logic [3*WIDTH+FRAC_BITS-1:0]  rem_im_i,
  input  logic [WIDTH-1:0]              q_re_i,
  input  logic [WIDTH-1:0]              q_im_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2*WIDTH-1:0]            den_o,
  output logic [3*WIDTH+FRAC_BITS-1:0]  rem_re_o,
  output logic [3*WIDTH+FRAC_BITS-1:0]  rem_im_o,
  output logic [WIDTH-1:0]              q_re_o,
  output logic [WIDTH-1:0]              q_im_o,
  output logic [SIDE_W-1:0]             side_o
);
  localparam int unsigned CW = 3*WIDTH + FRAC_BITS;

  logic              valid_q;
  logic [2*WIDTH-1:0] den_q;
  logic [CW-1:0]     rem_re_q, rem_im_q, dsh;
  logic [WIDTH-1:0]  q_re_q, q_im_q;
  logic [SIDE_W-1:0] side_q;
  logic              ge_re, ge_im;

  assign in_ready_o = !valid_q || out_ready_i;

  // one quotient bit: compare against the shifted divisor
  assign dsh   = CW'(den_i) << BIT;
  assign ge_re = rem_re_i >= dsh;
  assign ge_im = rem_im_i >= dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      den_q    <= den_i;
      side_q   <= side_i;
      rem_re_q <= ge_re ? rem_re_i - dsh : rem_re_i;
      rem_im_q <= ge_im ? rem_im_i - dsh : rem_im_i;
      q_re_q   <= q_re_i | (WIDTH'(ge_re) << BIT);
      q_im_q   <= q_im_i | (WIDTH'(ge_im) << BIT);
    end
  end

  assign out_valid_o = valid_q;
  assign den_o       = den_q;
  assign rem_re_o    = rem_re_q;
  assign rem_im_o    = rem_im_q;
  assign q_re_o      = q_re_q;
  assign q_im_o      = q_im_q;
  assign side_o      = side_q;

endmodule
